### rtl/fah_pkg.sv
// Shared types, constants and helpers for the facet area angle histogram.
package fah_pkg;

  localparam int NUM_BINS        = 100;
  localparam int COORD_FRAC_BITS = 16;
  localparam int ANG_BITS        = 30;
  localparam int CORDIC_ITERS    = 24;
  localparam int BIN_W           = $clog2(NUM_BINS);
  localparam int QUEUE_DEPTH     = 2;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] c_x;
    logic signed [31:0] c_y;
    logic signed [31:0] c_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } facet_in_t;

  typedef struct packed {
    logic [6:0]  bin_index;
    logic [55:0] facet_area;
    logic [63:0] bin_total;
    logic        normal_zero;
  } facet_out_t;

  // Front-end result handed to the accumulator.
  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [55:0]      area;
    logic             normal_zero;
  } fah_job_t;

  typedef logic signed [ANG_BITS+1:0] angle_t;

  function automatic angle_t step_angle(input logic [4:0] i);
    case (i)
      5'd0:  step_angle = 32'sd268435456;
      5'd1:  step_angle = 32'sd158466703;
      5'd2:  step_angle = 32'sd83729454;
      5'd3:  step_angle = 32'sd42502378;
      5'd4:  step_angle = 32'sd21333666;
      5'd5:  step_angle = 32'sd10677233;
      5'd6:  step_angle = 32'sd5339919;
      5'd7:  step_angle = 32'sd2670123;
      5'd8:  step_angle = 32'sd1335082;
      5'd9:  step_angle = 32'sd667543;
      5'd10: step_angle = 32'sd333772;
      5'd11: step_angle = 32'sd166886;
      5'd12: step_angle = 32'sd83443;
      5'd13: step_angle = 32'sd41722;
      5'd14: step_angle = 32'sd20861;
      5'd15: step_angle = 32'sd10430;
      5'd16: step_angle = 32'sd5215;
      5'd17: step_angle = 32'sd2608;
      5'd18: step_angle = 32'sd1304;
      5'd19: step_angle = 32'sd652;
      5'd20: step_angle = 32'sd326;
      5'd21: step_angle = 32'sd163;
      5'd22: step_angle = 32'sd81;
      5'd23: step_angle = 32'sd41;
      default: step_angle = '0;
    endcase
  endfunction

endpackage

### rtl/fah_front.sv
// Front end: facet area by cross product and bit-serial square root,
// elevation bin by bit-serial square root and CORDIC vectoring.
module fah_front import fah_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  facet_in_t in_data,
  output logic      job_valid,
  input  logic      job_ready,
  output fah_job_t  job
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MUL, S_CROSS, S_SQ, S_SUM, S_SQRT, S_HSQRT, S_SCALE,
    S_CORDIC, S_BIN, S_DONE
  } state_t;

  state_t state;

  facet_in_t f;
  logic signed [32:0] ux, uy, uz, wx, wy, wz;
  logic [2:0]  mcnt;
  logic [1:0]  sph;
  logic signed [65:0] prod [6];
  logic signed [66:0] crs [3];
  logic [135:0] ssum;
  logic [111:0] rad;       // value under the root, already shifted
  logic [57:0]  rem;
  logic [55:0]  root;
  logic [5:0]   bitn;
  logic         area_sat;
  logic [63:0]  hsq;
  logic [31:0]  hroot;
  logic signed [63:0] cx, cy;
  angle_t       cz;
  logic [4:0]   iter;
  logic         nzero, vert;

  // Shared 33x33 multiplier, operands picked by step counter.
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  always_comb begin
    case (mcnt)
      3'd0: begin ma = uy; mb = wz; end
      3'd1: begin ma = uz; mb = wy; end
      3'd2: begin ma = uz; mb = wx; end
      3'd3: begin ma = ux; mb = wz; end
      3'd4: begin ma = ux; mb = wy; end
      default: begin ma = uy; mb = wx; end
    endcase
    mp = ma * mb;
  end

  // Square one cross component in three partial products of 33-bit halves.
  logic signed [66:0] csel;
  logic [65:0]  cabs;
  logic [32:0]  sa, sb;
  logic [65:0]  sp;
  logic [135:0] sq_term;
  always_comb begin
    case (mcnt[1:0])
      2'd0:    csel = crs[0];
      2'd1:    csel = crs[1];
      default: csel = crs[2];
    endcase
    cabs = csel[66] ? 66'(-csel) : 66'(csel);
    case (sph)
      2'd0:    begin sa = cabs[32:0];  sb = cabs[32:0];  end
      2'd1:    begin sa = cabs[65:33]; sb = cabs[32:0];  end
      default: begin sa = cabs[65:33]; sb = cabs[65:33]; end
    endcase
    sp = sa * sb;
    case (sph)
      2'd0:    sq_term = 136'(sp);
      2'd1:    sq_term = 136'(sp) << 34;
      default: sq_term = 136'(sp) << 66;
    endcase
  end

  logic [57:0]  rem_sh, trial;
  logic [31:0]  hcand;
  logic [63:0]  hsq_c;
  assign rem_sh = {rem[55:0], rad[111:110]};
  assign trial  = {root, 2'b01};
  assign hcand = hroot | (32'd1 << bitn[4:0]);
  assign hsq_c = hcand * hcand;

  logic [31:0] mx, my;
  assign mx = f.normal_x[31] ? 32'(-f.normal_x) : 32'(f.normal_x);
  assign my = f.normal_y[31] ? 32'(-f.normal_y) : 32'(f.normal_y);

  logic signed [63:0] xs, ys;
  assign xs = cx >>> iter;
  assign ys = cy >>> iter;

  angle_t t;
  logic [ANG_BITS+8:0] tb;
  assign t  = cz + angle_t'(1 << (ANG_BITS - 1));
  assign tb = (t[ANG_BITS+1] ? '0 : (ANG_BITS+9)'(t)) * (ANG_BITS+9)'(NUM_BINS);

  assign in_ready  = (state == S_IDLE);
  assign job_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          f     <= in_data;
          state <= S_DIFF;
        end
        S_DIFF: begin
          ux <= 33'(f.b_x) - 33'(f.a_x);
          uy <= 33'(f.b_y) - 33'(f.a_y);
          uz <= 33'(f.b_z) - 33'(f.a_z);
          wx <= 33'(f.c_x) - 33'(f.a_x);
          wy <= 33'(f.c_y) - 33'(f.a_y);
          wz <= 33'(f.c_z) - 33'(f.a_z);
          nzero <= (f.normal_x == 0) && (f.normal_y == 0) && (f.normal_z == 0);
          hsq   <= 64'(mx) * 64'(mx) + 64'(my) * 64'(my);
          mcnt  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod[mcnt] <= mp;
          if (mcnt == 3'd5) state <= S_CROSS;
          else mcnt <= mcnt + 3'd1;
        end
        S_CROSS: begin
          for (int k = 0; k < 3; k++)
            crs[k] <= 67'(prod[2*k]) - 67'(prod[2*k+1]);
          mcnt  <= '0;
          sph   <= '0;
          ssum  <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          // accumulate one partial product per cycle
          ssum <= ssum + sq_term;
          if (sph == 2'd2) begin
            sph <= '0;
            if (mcnt == 3'd2) state <= S_SUM;
            else mcnt <= mcnt + 3'd1;
          end else sph <= sph + 2'd1;
        end
        S_SUM: begin
          rad      <= 112'(ssum >> (2 * COORD_FRAC_BITS + 2));
          area_sat <= |(ssum >> (2 * COORD_FRAC_BITS + 2 + 112));
          rem      <= '0;
          root     <= '0;
          bitn     <= 6'd55;
          state    <= S_SQRT;
        end
        S_SQRT: begin
          // one result bit per cycle, two radicand bits shifted in
          rad <= rad << 2;
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[54:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[54:0], 1'b0};
          end
          if (bitn == 6'd0) begin
            bitn  <= 6'd31;
            hroot <= '0;
            state <= S_HSQRT;
          end else bitn <= bitn - 6'd1;
        end
        S_HSQRT: begin
          if (hsq_c <= hsq) hroot <= hcand;
          if (bitn == 6'd0) state <= S_SCALE;
          else bitn <= bitn - 6'd1;
        end
        S_SCALE: begin
          vert  <= (hroot == 0);
          cx    <= 64'(hroot) << 8;
          cy    <= 64'(f.normal_z) <<< 8;
          cz    <= '0;
          iter  <= '0;
          // shift one place a cycle until the larger reaches 2^39
          if (hroot == 0 || f.normal_z == 0) state <= S_BIN;
          else state <= S_CORDIC;
          bitn <= 6'd0;
        end
        S_CORDIC: begin
          if (bitn == 6'd0 && ((cx[39] || cx[40]) == 1'b0) &&
              ((cy[63] ? -cy : cy) < 64'd549755813888) &&
              (cx < 64'd549755813888)) begin
            cx <= cx <<< 1;
            cy <= cy <<< 1;
          end else begin
            bitn <= 6'd1;
            if (cy >= 0) begin
              cx <= cx + ys; cy <= cy - xs; cz <= cz + step_angle(iter);
            end else begin
              cx <= cx - ys; cy <= cy + xs; cz <= cz - step_angle(iter);
            end
            if (iter == 5'(CORDIC_ITERS - 1)) state <= S_BIN;
            else iter <= iter + 5'd1;
          end
        end
        S_BIN: begin
          job.area        <= area_sat ? '1 : root;
          job.normal_zero <= nzero;
          if (nzero) job.bin <= '0;
          else if (vert) job.bin <= f.normal_z[31] ? '0 : BIN_W'(NUM_BINS - 1);
          else if ((tb >> ANG_BITS) >= NUM_BINS) job.bin <= BIN_W'(NUM_BINS - 1);
          else job.bin <= BIN_W'(tb >> ANG_BITS);
          state <= S_DONE;
        end
        S_DONE: if (job_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/fah_queue.sv
// Short job queue between the front end and the accumulator.
module fah_queue import fah_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  fah_job_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output fah_job_t rd_data
);

  fah_job_t mem [QUEUE_DEPTH];
  logic [$clog2(QUEUE_DEPTH)-1:0] wp, rp;
  logic [$clog2(QUEUE_DEPTH):0]   cnt;

  assign wr_ready = (cnt != ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH));
  assign rd_valid = (cnt != 0);
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= wp + 1'b1;
      if (rd_valid && rd_ready) rp <= rp + 1'b1;
      cnt <= cnt + ($clog2(QUEUE_DEPTH)+1)'(wr_valid && wr_ready)
                 - ($clog2(QUEUE_DEPTH)+1)'(rd_valid && rd_ready);
    end
  end

endmodule

### rtl/fah_accum.sv
// Back end: bin store read, saturating add, write back and output register.
module fah_accum import fah_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  output logic       job_ready,
  input  fah_job_t   job,
  output logic       out_valid,
  input  logic       out_ready,
  output facet_out_t out_data
);

  typedef enum logic [1:0] {A_IDLE, A_READ, A_ADD, A_OUT} state_t;
  state_t state;

  logic [63:0]      totals [NUM_BINS];
  logic [NUM_BINS-1:0] vld;
  logic [63:0]      rd_q;
  logic             rd_vld;
  fah_job_t         cur;
  logic [64:0]      sum;
  logic [63:0]      base;

  assign base = rd_vld ? rd_q : '0;
  assign sum  = 65'(base) + 65'(cur.area);
  assign job_ready = (state == A_IDLE);
  assign out_valid = (state == A_OUT);

  always_ff @(posedge clk) begin
    rd_q <= totals[cur.bin];
    if (state == A_ADD && !cur.normal_zero)
      totals[cur.bin] <= sum[64] ? '1 : sum[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      vld   <= '0;
    end else begin
      unique case (state)
        A_IDLE: if (job_valid) begin
          cur   <= job;
          state <= A_READ;
        end
        A_READ: begin
          rd_vld <= vld[cur.bin];
          state  <= A_ADD;
        end
        A_ADD: begin
          out_data.facet_area  <= cur.area;
          out_data.normal_zero <= cur.normal_zero;
          if (cur.normal_zero) begin
            out_data.bin_index <= '0;
            out_data.bin_total <= '0;
          end else begin
            vld[cur.bin]       <= 1'b1;
            out_data.bin_index <= 7'(cur.bin);
            out_data.bin_total <= sum[64] ? '1 : sum[63:0];
          end
          state <= A_OUT;
        end
        A_OUT: if (out_ready) state <= A_IDLE;
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

### rtl/facet_area_angle_histogram.sv
// Facet area and normal-elevation histogram. For each facet transaction the
// front end runs six cross-product multiplies on one shared multiplier, nine
// partial products to square the three cross components, a 56-step
// bit-serial area root, a 32-step root of the normal's horizontal length, up
// to 31 normalizing shifts and 24 CORDIC steps, done one per cycle. Vertical,
// horizontal and zero normals skip the shifts and CORDIC. The accumulator
// steps through its read, add and output states per transaction and runs
// behind a two-entry queue, so the front end sets the throughput. Bin totals
// start at zero after reset through per-bin valid bits; no clearing pass.
module facet_area_angle_histogram import fah_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  facet_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output facet_out_t out_data
);

  logic     f_valid, f_ready, q_valid, q_ready;
  fah_job_t f_job, q_job;

  fah_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  fah_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
  );

  fah_accum u_accum (
    .clk, .rst,
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_valid, .out_ready, .out_data
  );

`ifndef ASSERT_OFF
  a_zero_bin: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.normal_zero |-> out_data.bin_index == 0 &&
    out_data.bin_total == 0) else $error("zero normal with nonzero bin");
  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.bin_index < NUM_BINS) else $error("bin out of range");
  a_total_ge: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.normal_zero |->
    out_data.bin_total >= 64'(out_data.facet_area)) else $error("total below area");
`endif

endmodule
